// ----- hw/rtl/fsd_pkg.sv -----
package fsd_pkg;

    localparam logic [2:0] REQ_LOAD_PLAIN = 3'd0;
    localparam logic [2:0] REQ_LOAD_KEY1  = 3'd1;
    localparam logic [2:0] REQ_LOAD_KEY2  = 3'd2;
    localparam logic [2:0] REQ_DECRYPT    = 3'd3;
    localparam logic [2:0] REQ_CLEAR      = 3'd4;

    typedef enum logic [2:0] {
        OP_PLAIN,
        OP_KEY1,
        OP_KEY2,
        OP_DECRYPT,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [4:0] pos;
        logic [7:0] letter;
        logic [7:0] c1;
        logic [7:0] c2;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

endpackage

// ----- hw/rtl/fsd_front.sv -----
module fsd_front #(
    parameter int SQUARE_SIDE = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [2:0]    i_req_type,
    input  logic [4:0]    i_square_position,
    input  logic [7:0]    i_entry_letter,
    input  logic [7:0]    i_cipher_first,
    input  logic [7:0]    i_cipher_second,
    output fsd_pkg::t_head o_head,
    input  logic          i_take
);
    import fsd_pkg::*;

    localparam int CELLS = SQUARE_SIDE * SQUARE_SIDE;

    t_cmd       cls_cmd;
    logic       keep;
    logic       pos_ok;
    logic       wr;
    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    always_comb begin
        pos_ok         = int'(i_square_position) < CELLS;
        cls_cmd.pos    = i_square_position;
        cls_cmd.letter = i_entry_letter;
        cls_cmd.c1     = i_cipher_first;
        cls_cmd.c2     = i_cipher_second;
        cls_cmd.op     = OP_CLEAR;
        keep           = 1'b0;
        unique case (i_req_type)
            REQ_LOAD_PLAIN: begin
                cls_cmd.op = OP_PLAIN;
                keep       = pos_ok;
            end
            REQ_LOAD_KEY1: begin
                cls_cmd.op = OP_KEY1;
                keep       = pos_ok;
            end
            REQ_LOAD_KEY2: begin
                cls_cmd.op = OP_KEY2;
                keep       = pos_ok;
            end
            REQ_DECRYPT: begin
                cls_cmd.op = OP_DECRYPT;
                keep       = 1'b1;
            end
            REQ_CLEAR: begin
                cls_cmd.op = OP_CLEAR;
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_full = (r_count == 2'd2);
    assign wr     = i_push && !o_full && keep;

    always_comb begin
        unique case ({wr, i_take})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_take) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_slot[r_wr_ptr] <= cls_cmd;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.cmd   = r_slot[r_rd_ptr];

endmodule

// ----- hw/rtl/fsd_back.sv -----
module fsd_back #(
    parameter int SQUARE_SIDE = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fsd_pkg::t_head i_head,
    output logic           o_take,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [7:0]     o_plain_first,
    output logic [7:0]     o_plain_second,
    output logic           o_letter_missing
);
    import fsd_pkg::*;

    localparam int CELLS = SQUARE_SIDE * SQUARE_SIDE;
    localparam int RB    = $clog2(SQUARE_SIDE);
    localparam int IW    = $clog2(CELLS);
    localparam int PW    = 2 * RB;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_KEY   = 4'b0010,
        ST_MAP   = 4'b0100,
        ST_PLAIN = 4'b1000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    t_cmd          r_cmd;
    logic [255:0]  r_known1;
    logic [255:0]  r_known2;
    logic [PW-1:0] r_place1 [256];
    logic [PW-1:0] r_place2 [256];
    logic [PW-1:0] r_p1_q;
    logic [PW-1:0] r_p2_q;
    logic [7:0]    r_plain [CELLS];
    logic [7:0]    r_pl1_q;
    logic [7:0]    r_pl2_q;
    logic          r_out_valid;
    logic [7:0]    r_out_first;
    logic [7:0]    r_out_second;
    logic          r_out_missing;

    logic          out_ready;
    logic          rd1_en;
    logic          rd2_en;
    logic [7:0]    rd1_addr;
    logic [7:0]    rd2_addr;
    logic          is_key1;
    logic          cur_known;
    logic [PW-1:0] old_place;
    logic [PW-1:0] new_place;
    logic          upd;
    logic          we1;
    logic          we2;
    logic          miss;
    logic [RB-1:0] a_row;
    logic [RB-1:0] a_col;
    logic [RB-1:0] b_row;
    logic [RB-1:0] b_col;
    logic [IW-1:0] idx1;
    logic [IW-1:0] idx2;
    logic          pl_rd;
    logic          pl_we;
    logic          clr;
    logic          out_we;

    function automatic logic [RB-1:0] row_of(input logic [4:0] p);
        logic [RB-1:0] r;
        r = '0;
        for (int k = 1; k < SQUARE_SIDE; k++) begin
            if (int'(p) >= k * SQUARE_SIDE) begin
                r = RB'(k);
            end
        end
        return r;
    endfunction

    function automatic logic [RB-1:0] col_of(input logic [4:0] p);
        logic [4:0] c;
        c = p - 5'(int'(row_of(p)) * SQUARE_SIDE);
        return c[RB-1:0];
    endfunction

    assign out_ready = !r_out_valid || i_pop;
    assign o_take    = (r_state == ST_IDLE) && i_head.valid;

    assign rd1_en   = o_take && (i_head.cmd.op == OP_KEY1 || i_head.cmd.op == OP_DECRYPT);
    assign rd2_en   = o_take && (i_head.cmd.op == OP_KEY2 || i_head.cmd.op == OP_DECRYPT);
    assign rd1_addr = (i_head.cmd.op == OP_DECRYPT) ? i_head.cmd.c1 : i_head.cmd.letter;
    assign rd2_addr = (i_head.cmd.op == OP_DECRYPT) ? i_head.cmd.c2 : i_head.cmd.letter;
    assign pl_we    = o_take && (i_head.cmd.op == OP_PLAIN);
    assign clr      = o_take && (i_head.cmd.op == OP_CLEAR);

    assign is_key1   = (r_cmd.op == OP_KEY1);
    assign cur_known = is_key1 ? r_known1[r_cmd.letter] : r_known2[r_cmd.letter];
    assign old_place = is_key1 ? r_p1_q : r_p2_q;
    assign new_place = {row_of(r_cmd.pos), col_of(r_cmd.pos)};
    assign upd       = (r_state == ST_KEY) && (!cur_known || new_place < old_place);
    assign we1       = upd && is_key1;
    assign we2       = upd && !is_key1;

    assign miss  = !r_known1[r_cmd.c1] || !r_known2[r_cmd.c2];
    assign a_row = r_p1_q[PW-1:RB];
    assign a_col = r_p1_q[RB-1:0];
    assign b_row = r_p2_q[PW-1:RB];
    assign b_col = r_p2_q[RB-1:0];
    assign idx1  = IW'(int'(a_row) * SQUARE_SIDE + int'(b_col));
    assign idx2  = IW'(int'(b_row) * SQUARE_SIDE + int'(a_col));
    assign pl_rd = (r_state == ST_MAP) && !miss;

    assign out_we = ((r_state == ST_MAP) && miss && out_ready)
                 || ((r_state == ST_PLAIN) && out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_take) begin
                    if (i_head.cmd.op == OP_KEY1 || i_head.cmd.op == OP_KEY2) begin
                        n_state = ST_KEY;
                    end else if (i_head.cmd.op == OP_DECRYPT) begin
                        n_state = ST_MAP;
                    end
                end
            end
            ST_KEY: begin
                n_state = ST_IDLE;
            end
            ST_MAP: begin
                if (!miss) begin
                    n_state = ST_PLAIN;
                end else if (out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PLAIN: begin
                if (out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_known1    <= '0;
            r_known2    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clr) begin
                r_known1 <= '0;
                r_known2 <= '0;
            end else begin
                if (we1) begin
                    r_known1[r_cmd.letter] <= 1'b1;
                end
                if (we2) begin
                    r_known2[r_cmd.letter] <= 1'b1;
                end
            end
            if (out_we) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_cmd <= i_head.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we1) begin
            r_place1[r_cmd.letter] <= new_place;
        end
        if (rd1_en) begin
            r_p1_q <= r_place1[rd1_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we2) begin
            r_place2[r_cmd.letter] <= new_place;
        end
        if (rd2_en) begin
            r_p2_q <= r_place2[rd2_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pl_we) begin
            r_plain[IW'(i_head.cmd.pos)] <= i_head.cmd.letter;
        end
        if (pl_rd) begin
            r_pl1_q <= r_plain[idx1];
            r_pl2_q <= r_plain[idx2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_we) begin
            if (r_state == ST_MAP) begin
                r_out_first   <= r_cmd.c1;
                r_out_second  <= r_cmd.c2;
                r_out_missing <= 1'b1;
            end else begin
                r_out_first   <= r_pl1_q;
                r_out_second  <= r_pl2_q;
                r_out_missing <= 1'b0;
            end
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_plain_first    = r_out_first;
    assign o_plain_second   = r_out_second;
    assign o_letter_missing = r_out_missing;

endmodule

// ----- hw/rtl/four_square_digram_decrypt.sv -----
// Four-square digram decryption with loadable plain and keyed squares.
// Requests enter through a queue-style port: a word is taken at a rising
// edge where push is high and full is low. The request type selects a plain
// square load, a key one or key two load, a digram decrypt or a map clear.
// Loads and clears give no result; a decrypt gives exactly one result word.
// Results leave through a second queue-style port: the oldest result is
// shown while empty is low and is taken at an edge where pop is high.
// A two-word request queue parts the front from the execution sequencer.
// The sequencer handles a plain load or a clear as it takes the request, a
// key load as a read, then a compare and write of the letter map, and a
// decrypt as a map read, then a plain square read unless a letter is
// missing. A decrypt result is registered once the result port is free.
// Synchronous reset empties both queues and clears the letter known bits;
// the squares keep their contents until rewritten.
// When the receiver does not pop, the result is held, a later decrypt waits,
// and full rises once two more requests are queued behind it.
module four_square_digram_decrypt #(
    parameter int SQUARE_SIDE = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] i_req_type,
    input  logic [4:0] i_square_position,
    input  logic [7:0] i_entry_letter,
    input  logic [7:0] i_cipher_first,
    input  logic [7:0] i_cipher_second,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_plain_first,
    output logic [7:0] o_plain_second,
    output logic       o_letter_missing
);
    import fsd_pkg::*;

    t_head head;
    logic  take;

    fsd_front #(
        .SQUARE_SIDE(SQUARE_SIDE)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_req_type       (i_req_type),
        .i_square_position(i_square_position),
        .i_entry_letter   (i_entry_letter),
        .i_cipher_first   (i_cipher_first),
        .i_cipher_second  (i_cipher_second),
        .o_head           (head),
        .i_take           (take)
    );

    fsd_back #(
        .SQUARE_SIDE(SQUARE_SIDE)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .o_take          (take),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_plain_first   (o_plain_first),
        .o_plain_second  (o_plain_second),
        .o_letter_missing(o_letter_missing)
    );

endmodule

// ----- hw/rtl/fsd_checker.sv -----
module fsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_plain_first,
    input logic [7:0] o_plain_second,
    input logic       o_letter_missing
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("Result port is not empty after reset.");

    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("Request port is full after reset.");

    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push && !full))
        else $error("Full rose without a request word taken.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_plain_first)
            && $stable(o_plain_second) && $stable(o_letter_missing)))
        else $error("Stalled result word changed or vanished.");

endmodule

bind four_square_digram_decrypt fsd_checker u_fsd_checker (.*);
